>>> rtl/mcdsp_pkg.sv
// types and constants shared by the soft pwm block
`timescale 1ns / 1ps

package mcdsp_pkg;

   localparam int MAX_FANS   = 8;
   localparam int CH_W       = 3;
   localparam int DUTY_W     = 8;
   localparam int PHASE_W    = 8;
   localparam int SCALE_W    = 3;
   localparam int CSR_DATA_W = 3;

   localparam logic [PHASE_W-1:0] WRAP_POINT  = 8'd127;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 3'd1;

   typedef enum logic [1:0] {
      CSR_SCALE  = 2'd0,
      CSR_DITHER = 2'd1,
      CSR_SLOW   = 2'd2,
      CSR_INVERT = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_DUTY = 1'b1
   } mode_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      logic               dither;
      logic               slow;
      logic               invert;
   } cfg_type;

   // per-tick control broadcast from the phase counter to every channel
   typedef struct packed {
      logic               tick;
      logic               wrap;
      logic [PHASE_W-1:0] t;
      logic [PHASE_W-1:0] mask;
   } tick_ctl_type;

endpackage

>>> rtl/mcdsp_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface mcdsp_req_if;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic [mcdsp_pkg::CH_W-1:0]   channel;
   logic [mcdsp_pkg::DUTY_W-1:0] duty;

   modport source (output valid, output mode, output channel, output duty, input ready);
   modport sink   (input valid, input mode, input channel, input duty, output ready);
endinterface

interface mcdsp_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mcdsp_pkg::MAX_FANS-1:0] fan_pins;

   modport source (output valid, output fan_pins, input ready);
   modport sink   (input valid, input fan_pins, output ready);
endinterface

>>> rtl/multi_channel_dithered_soft_pwm_unit.sv
// top level of the multi-channel dithered soft pwm unit
`timescale 1ns / 1ps

// Software-style PWM for up to NUM_FANS fan outputs. Each request transaction is
// either one pwm tick (mode 0) or a duty write to one channel (mode 1); every
// request yields exactly one response transaction carrying the fan pin levels
// after it. The unit takes one transaction per clock cycle when the response
// side keeps up: the request is held in an input register, all channels
// update in parallel from registered state, and the pins land in the
// response register. Configuration writes on the csr port are taken at any
// edge with csr_we high and are meant for idle time; a write of scale reloads
// the phase to 2^scale. Pins of missing fans read 0.

module multi_channel_dithered_soft_pwm_unit #(
   parameter int NUM_FANS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   mcdsp_req_if.sink                        req_ch,
   mcdsp_rsp_if.source                      rsp_ch,
   input  logic                             csr_we,
   input  mcdsp_pkg::csr_index_type         csr_index,
   input  logic [mcdsp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcdsp_pkg::*;

   // bits of fan_pins that have a fan behind them
   localparam logic [MAX_FANS-1:0] FAN_MASK = MAX_FANS'((1 << NUM_FANS) - 1);

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input register stage
   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic [CH_W-1:0]   in_channel_ff;
   logic [DUTY_W-1:0] in_duty_ff;

   // response register stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MAX_FANS-1:0] rsp_pins_ff;

   logic                advance;
   logic                do_item;
   logic                tick;
   logic                scale_we;
   tick_ctl_type        ctl;
   logic [MAX_FANS-1:0] pin_next;
   logic [MAX_FANS-1:0] pins_out;

   // the response register frees up whenever it is empty or being taken
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign do_item      = in_valid_ff && advance;
   assign tick         = do_item && (in_mode_ff == MODE_TICK);
   assign scale_we     = csr_we && (csr_index == CSR_SCALE);

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.fan_pins = rsp_pins_ff;

   // csr decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:  cfg_in.scale  = csr_wdata[SCALE_W-1:0];
            CSR_DITHER: cfg_in.dither = csr_wdata[0];
            CSR_SLOW:   cfg_in.slow   = csr_wdata[0];
            CSR_INVERT: cfg_in.invert = csr_wdata[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = in_valid_ff;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      pins_out = (pin_next ^ {MAX_FANS{cfg_ff.invert}}) & FAN_MASK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{scale: SCALE_RESET, dither: 1'b0, slow: 1'b0, invert: 1'b0};
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_mode_ff    <= req_ch.mode;
         in_channel_ff <= req_ch.channel;
         in_duty_ff    <= req_ch.duty;
      end
      if (do_item) begin
         rsp_pins_ff <= pins_out;
      end
   end

   mcdsp_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .scale_we    (scale_we),
      .scale_wdata (csr_wdata[SCALE_W-1:0]),
      .tick        (tick),
      .ctl         (ctl)
   );

   // one channel per fan, unused pin slots tie low
   for (genvar i = 0; i < MAX_FANS; i++) begin : g_fan
      if (i < NUM_FANS) begin : g_on
         logic duty_we;
         assign duty_we = do_item && (in_mode_ff == MODE_DUTY)
                          && (in_channel_ff == CH_W'(i));
         mcdsp_channel u_channel (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .duty_we    (duty_we),
            .duty_wdata (in_duty_ff),
            .pin_next   (pin_next[i])
         );
      end else begin : g_off
         assign pin_next[i] = 1'b0;
      end
   end

   // a held request must not vanish while the response side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("input stage dropped a stalled request");

   // every processed request produces a response
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      do_item |=> rsp_valid_ff)
      else $error("processed request produced no response");

   // missing fans never drive a pin
   a_no_ghost_fans: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_pins_ff & ~FAN_MASK) == '0))
      else $error("pin of a missing fan is set");

endmodule

>>> rtl/mcdsp_phase.sv
// phase counter and wrap detection for the soft pwm
`timescale 1ns / 1ps

module mcdsp_phase (
   input  logic                              clock,
   input  logic                              reset,
   input  mcdsp_pkg::cfg_type                cfg,
   input  logic                              scale_we,
   input  logic [mcdsp_pkg::SCALE_W-1:0]     scale_wdata,
   input  logic                              tick,
   output mcdsp_pkg::tick_ctl_type           ctl
);
   import mcdsp_pkg::*;

   logic [PHASE_W-1:0] phase_ff;
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W-1:0] step;
   logic               wrap;
   logic [PHASE_W-1:0] t;

   always_comb begin
      step = PHASE_W'(1) << cfg.scale;
      wrap = (phase_ff >= WRAP_POINT);
      if (!wrap) begin
         t = phase_ff;
      end else if (cfg.slow) begin
         t = '0;
      end else begin
         t = phase_ff - WRAP_POINT;
      end

      ctl.tick = tick;
      ctl.wrap = wrap;
      ctl.t    = t;
      // slow mode reloads without remainder, so its mask is zero too
      ctl.mask = (cfg.dither && !cfg.slow) ? step - PHASE_W'(1) : '0;

      priority if (scale_we) begin
         phase_in = PHASE_W'(1) << scale_wdata;
      end else if (tick) begin
         phase_in = t + step;
      end else begin
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_W'(1) << SCALE_RESET;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

>>> rtl/mcdsp_channel.sv
// one fan channel: duty, accumulator and pin level
`timescale 1ns / 1ps

module mcdsp_channel (
   input  logic                         clock,
   input  logic                         reset,
   input  mcdsp_pkg::tick_ctl_type      ctl,
   input  logic                         duty_we,
   input  logic [mcdsp_pkg::DUTY_W-1:0] duty_wdata,
   output logic                         pin_next
);
   import mcdsp_pkg::*;

   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [PHASE_W-1:0] acc_ff, acc_in;
   logic               pin_ff, pin_in;
   logic [PHASE_W-1:0] reload;

   always_comb begin
      reload  = (acc_ff & ctl.mask) + PHASE_W'(duty_ff >> 1);
      duty_in = duty_we ? duty_wdata : duty_ff;
      acc_in  = acc_ff;
      pin_in  = pin_ff;
      if (ctl.tick) begin
         if (ctl.wrap) begin
            acc_in = reload;
            pin_in = (reload > ctl.mask);
         end else if (acc_ff <= ctl.t) begin
            pin_in = 1'b0;
         end
      end
      pin_next = pin_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
         acc_ff  <= '0;
         pin_ff  <= 1'b0;
      end else begin
         duty_ff <= duty_in;
         acc_ff  <= acc_in;
         pin_ff  <= pin_in;
      end
   end

endmodule
